>>> rtl/csvt_pkg.sv
package csvt_pkg;

  // Character codes
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Result kinds
  localparam logic [1:0] KindData   = 2'd0;
  localparam logic [1:0] KindField  = 2'd1;
  localparam logic [1:0] KindRecord = 2'd2;

  // Field phase codes
  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhPlain  = 2'd1;
  localparam logic [1:0] PhQuoted = 2'd2;
  localparam logic [1:0] PhQuote  = 2'd3;

  // Results one byte can cause, and the result queue behind the parser
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic       quote_parity;
    logic [1:0] field_phase;
    logic       pending_cr;
    logic       record_open;
  } state_t;

  typedef struct packed {
    logic       last;
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

endpackage

>>> rtl/csv_byte_stream_tokenizer.sv
// Channel   Dir  Word                 tuser          tlast
// s_axis    in   tdata[7:0] in_byte   end_of_input   -
// m_axis    out  tdata[7:0] out_byte  out_kind[1:0]  last
//
// A word is held in the input register, where the parser state is
// applied; its 0 to 3 results go into a 4-entry result queue and leave one
// per cycle while the output is ready.
// Sustained rate: one word per cycle while each word gives at most one
// result and the output is ready.
// The input register moves only when the queue has room for all its results.
// Reset clears the parser state, the input valid and the queue.
module csv_byte_stream_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tuser_i,  // [0] end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,  // [1:0] out_kind
  output logic       m_axis_tlast_o
);
  import csvt_pkg::*;

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_eoi_q;
  logic               in_move;
  state_t             state_q, state_d;
  logic [ResCntW-1:0] step_n;
  res_t [MaxRes-1:0]  step_res;
  res_t               q_q [QDepth];
  logic [QAddrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;
  logic [QCntW-1:0]   free;
  logic               pop;

  csvt_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .eoi_i   (in_eoi_q),
    .state_o (state_d),
    .res_n_o (step_n),
    .res_o   (step_res)
  );

  assign free    = QCntW'(QDepth) - cnt_q;
  assign in_move = in_valid_q && (QCntW'(step_n) <= free);
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = !in_valid_q || in_move;

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = q_q[rd_q].data;
  assign m_axis_tuser_o  = q_q[rd_q].kind;
  assign m_axis_tlast_o  = q_q[rd_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (in_move) begin
        state_q <= state_d;
        wr_q    <= wr_q + QAddrW'(step_n);
      end
      if (pop) rd_q <= rd_q + QAddrW'(1);
      cnt_q <= cnt_q + (in_move ? QCntW'(step_n) : '0) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i;
    end
    if (in_move) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (ResCntW'(i) < step_n) q_q[wr_q + QAddrW'(i)] <= step_res[i];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overfilled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_move |-> (QCntW'(step_n) <= free))
    else $error("results pushed without room");

  a_eoi_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_move && in_eoi_q) |=> (state_q == '0))
    else $error("state not cleared after end of input");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("stalled with empty input register");

endmodule

>>> rtl/csvt_step.sv
module csvt_step (
  input  csvt_pkg::state_t                      state_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  eoi_i,
  output csvt_pkg::state_t                      state_o,
  output logic [csvt_pkg::ResCntW-1:0]          res_n_o,
  output csvt_pkg::res_t [csvt_pkg::MaxRes-1:0] res_o
);
  import csvt_pkg::*;

  typedef struct packed {
    state_t     st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } take_t;

  function automatic take_t push(take_t t_in, logic [1:0] kind, logic [7:0] data);
    take_t t;
    res_t  r;
    t = t_in;
    r.last = 1'b0;
    r.kind = kind;
    r.data = (kind == KindData) ? data : 8'h00;
    if (t.n == 2'd0) begin
      t.r0 = r;
    end else begin
      t.r1 = r;
    end
    t.n = t.n + 2'd1;
    return t;
  endfunction

  // One byte that is not a held-CR decision; at most two results
  function automatic take_t take(state_t st, logic [7:0] b);
    take_t      t;
    logic       cont;
    logic [1:0] ph;
    t.st = st;
    t.n = 2'd0;
    t.r0 = '0;
    t.r1 = '0;
    cont = 1'b1;
    ph = st.field_phase;
    if (b == ChLf && !st.quote_parity) begin
      t = push(t, KindRecord, 8'h00);
      t.st.quote_parity = 1'b0;
      t.st.field_phase = PhStart;
      t.st.record_open = 1'b0;
    end else begin
      t.st.record_open = 1'b1;
      if (ph == PhQuote) begin
        if (b == ChQuote) begin
          // doubled quote: emit one quote
          t.st.quote_parity = ~t.st.quote_parity;
          t.st.field_phase = PhQuoted;
          t = push(t, KindData, ChQuote);
          cont = 1'b0;
        end else begin
          t = push(t, KindField, 8'h00);
          ph = PhStart;
          t.st.field_phase = PhStart;
          if (b == ChComma) cont = 1'b0;
        end
      end
      if (cont) begin
        case (ph)
          PhStart: begin
            if (b == ChQuote) begin
              t.st.quote_parity = ~t.st.quote_parity;
              t.st.field_phase = PhQuoted;
            end else if (b == ChComma) begin
              t = push(t, KindField, 8'h00);
            end else begin
              t.st.field_phase = PhPlain;
              t = push(t, KindData, b);
            end
          end
          PhPlain: begin
            if (b == ChComma) begin
              t.st.field_phase = PhStart;
              t = push(t, KindField, 8'h00);
            end else begin
              if (b == ChQuote) t.st.quote_parity = ~t.st.quote_parity;
              t = push(t, KindData, b);
            end
          end
          default: begin
            if (b == ChQuote) begin
              t.st.quote_parity = ~t.st.quote_parity;
              t.st.field_phase = PhQuote;
            end else begin
              t = push(t, KindData, b);
            end
          end
        endcase
      end
    end
    return t;
  endfunction

  always_comb begin
    take_t                     t;
    state_t                    s;
    res_t [MaxRes-1:0]         r;
    logic [ResCntW-1:0]        n;
    res_t                      rec;
    s = state_i;
    r = '0;
    n = '0;
    t = '0;
    rec.last = 1'b0;
    rec.kind = KindRecord;
    rec.data = 8'h00;

    if (eoi_i) begin
      if (s.pending_cr) begin
        s.pending_cr = 1'b0;
        t = take(s, ChCr);
        s = t.st;
        if (t.n > 2'd0) begin
          r[0] = t.r0;
          n = ResCntW'(1);
        end
        if (t.n > 2'd1) begin
          r[1] = t.r1;
          n = ResCntW'(2);
        end
      end
      if (s.record_open) begin
        r[n[1:0]] = rec;
        n = n + ResCntW'(1);
      end
      s = '0;
    end else if (byte_i == ChCr) begin
      if (s.pending_cr) begin
        t = take(s, ChCr);
        s = t.st;
        if (t.n > 2'd0) begin
          r[0] = t.r0;
          n = ResCntW'(1);
        end
        if (t.n > 2'd1) begin
          r[1] = t.r1;
          n = ResCntW'(2);
        end
      end
      s.pending_cr = 1'b1;
      s.record_open = 1'b1;
    end else begin
      if (s.pending_cr) begin
        s.pending_cr = 1'b0;
        // a CR not followed by LF is an ordinary byte
        if (byte_i != ChLf) begin
          t = take(s, ChCr);
          s = t.st;
          if (t.n > 2'd0) begin
            r[0] = t.r0;
            n = ResCntW'(1);
          end
          if (t.n > 2'd1) begin
            r[1] = t.r1;
            n = ResCntW'(2);
          end
        end
      end
      t = take(s, byte_i);
      s = t.st;
      if (t.n > 2'd0) begin
        r[n[1:0]] = t.r0;
        n = n + ResCntW'(1);
      end
      if (t.n > 2'd1) begin
        r[n[1:0]] = t.r1;
        n = n + ResCntW'(1);
      end
    end

    if (n != '0) r[n[1:0] - 2'd1].last = 1'b1;

    state_o = s;
    res_n_o = n;
    res_o   = r;
  end

endmodule

>>> verif/csv_byte_stream_tokenizer_tb.sv
`timescale 1ns / 1ps

module csv_byte_stream_tokenizer_tb;
  import csvt_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;  // [7:0] in_byte
  logic       s_axis_tuser_i;  // [0] end_of_input
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;  // [7:0] out_byte
  logic [1:0] m_axis_tuser_o;  // [1:0] out_kind
  logic       m_axis_tlast_o;

  csv_byte_stream_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Tokenizer state as predicted
  logic       quote_odd = 1'b0;
  logic [1:0] phase     = PhStart;
  logic       cr_held   = 1'b0;
  logic       rec_open  = 1'b0;

  res_t word_tokens[$];  // tokens of the word being predicted
  res_t token_q[$];      // tokens still owed by the block

  int unsigned s_idle_pct = 0;
  int unsigned r_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;
  logic        hold_req   = 1'b0;
  logic        hold_taken = 1'b0;
  int          errors     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void emit(logic [1:0] kind, logic [7:0] b);
    word_tokens.push_back('{last: 1'b0, kind: kind, data: (kind == KindData) ? b : 8'h00});
  endfunction

  function automatic void close_record();
    quote_odd = 1'b0;
    phase     = PhStart;
    rec_open  = 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    if (b == ChLf && !quote_odd) begin
      emit(KindRecord, 8'h00);
      close_record();
      return;
    end
    rec_open = 1'b1;
    if (phase == PhQuote) begin
      if (b == ChQuote) begin
        quote_odd ^= 1'b1;
        phase = PhQuoted;
        emit(KindData, ChQuote);
        return;
      end
      emit(KindField, 8'h00);
      phase = PhStart;
      if (b == ChComma) return;
      // anything else after a closing quote opens a new field
    end
    case (phase)
      PhStart: begin
        if (b == ChQuote) begin
          quote_odd ^= 1'b1;
          phase = PhQuoted;
        end else if (b == ChComma) begin
          emit(KindField, 8'h00);
        end else begin
          phase = PhPlain;
          emit(KindData, b);
        end
      end
      PhPlain: begin
        if (b == ChComma) begin
          phase = PhStart;
          emit(KindField, 8'h00);
        end else begin
          if (b == ChQuote) quote_odd ^= 1'b1;
          emit(KindData, b);
        end
      end
      default: begin
        if (b == ChQuote) begin
          quote_odd ^= 1'b1;
          phase = PhQuote;
        end else begin
          emit(KindData, b);
        end
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eoi);
    word_tokens.delete();
    if (eoi) begin
      if (cr_held) begin
        cr_held = 1'b0;
        parse_byte(ChCr);
      end
      if (rec_open) emit(KindRecord, 8'h00);
      close_record();
      cr_held = 1'b0;
    end else if (b == ChCr) begin
      // hold the CR until the next byte shows whether an LF follows
      if (cr_held) parse_byte(ChCr);
      cr_held  = 1'b1;
      rec_open = 1'b1;
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        if (b != ChLf) parse_byte(ChCr);
      end
      parse_byte(b);
    end
    if (word_tokens.size() > 0) word_tokens[$].last = 1'b1;
    foreach (word_tokens[i]) token_q.push_back(word_tokens[i]);
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected word: kind %0d byte %02h last %0b",
               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = token_q.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold on request
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready_i <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = 80;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= r_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_tokens(b, eoi);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChQuote || b == ChComma || b == ChLf || b == ChCr);
    return b;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 3))
      0:       return ChQuote;
      1:       return ChComma;
      2:       return ChLf;
      default: return ChCr;
    endcase
  endfunction

  // One record of random fields, quoted or plain, ended by LF, CRLF or end of text
  task automatic send_record();
    int unsigned nfields;
    int unsigned len;
    nfields = $urandom_range(1, 3);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) send_word(ChComma, 1'b0);
      len = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) begin
        send_word(ChQuote, 1'b0);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: send_word(ChComma, 1'b0);
            1: send_word(ChLf, 1'b0);
            2: send_word(ChCr, 1'b0);
            3: begin
              send_word(ChQuote, 1'b0);
              send_word(ChQuote, 1'b0);
            end
            default: send_word(plain_byte(), 1'b0);
          endcase
        end
        send_word(ChQuote, 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_word(plain_byte(), 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        send_word(ChCr, 1'b0);
        send_word(ChLf, 1'b0);
      end
      3:       send_word(8'($urandom_range(0, 255)), 1'b1);
      default: send_word(ChLf, 1'b0);
    endcase
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_word(8'($urandom_range(0, 255)), 1'b1);
      else if ($urandom_range(0, 1) == 0)
        send_word(special_byte(), 1'b0);
      else
        send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_directed_text();
    s_idle_pct = 0;
    r_idle_pct = 0;
    // CRLF ending after a trailing comma, then an empty line
    send_text("a,");
    send_word(ChCr, 1'b0);
    send_word(ChLf, 1'b0);
    send_word(ChLf, 1'b0);
    // doubled quote, then a byte right after the closing quote
    send_text("\"\"\"x\"y,");
    // quote inside a plain field makes the LF data; CR not followed by LF
    send_text("a\"b");
    send_word(ChLf, 1'b0);
    send_word(ChCr, 1'b0);
    send_word(ChCr, 1'b0);
    send_text("z");
    send_word(8'h00, 1'b1);
    // end of text with nothing open
    send_word(8'hFF, 1'b1);
    // byte extremes, held CR at end of text
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(ChCr, 1'b0);
    send_word(ChComma, 1'b1);
    // unterminated quote flushed at end of text
    send_word(ChQuote, 1'b0);
    send_word(ChQuote, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_text(input int unsigned s_pct, input int unsigned r_pct,
                                  input int unsigned budget);
    int unsigned start;
    s_idle_pct = s_pct;
    r_idle_pct = r_pct;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_record();
    end
    wait_for_drain();
  endtask

  // Hold the output long enough for the result queue to fill and stall the input
  task automatic test_output_stall();
    int unsigned start;
    s_idle_pct = 0;
    r_idle_pct = 0;
    hold_req <= 1'b1;
    start = words_sent;
    while (words_sent - start < 30) send_record();
    wait_for_drain();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tuser_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_text();
    test_random_text(7, 88, 50);
    test_random_text(88, 7, 50);
    test_random_text(0, 0, 50);
    test_output_stall();

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
